@@ hw/rtl/stem_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package stem_pkg;

  // fixed field widths
  localparam int POS_W = 5;
  localparam int CFG_W = 6;
  localparam int REG_W = 1;
  // wide enough for a clamped grid dimension up to 256 and for a coordinate plus one
  localparam int DIM_W = 9;

  localparam logic [CFG_W-1:0] GRID_RESET = 6'd32;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_EDGE  = 1'b1;

  localparam logic DIR_RIGHT = 1'b0;
  localparam logic DIR_DOWN  = 1'b1;

  localparam logic [REG_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [REG_W-1:0] REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL,
    ST_LOOK1,
    ST_LOOK2,
    ST_CMP,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } stem_state_e;

  typedef struct packed {
    logic load_in;
    logic cnt_clr;
    logic cnt_inc;
    logic fill_we;
    logic rd_i1;
    logic rd_i2;
    logic rd_scan;
    logic cap_keep;
    logic cap_gone;
    logic set_removed;
    logic load_out;
  } stem_cmd_t;

  typedef struct packed {
    logic in_fire;
    logic start;
    logic invalid;
    logic cnt_last;
    logic differ;
    logic out_free;
  } stem_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/spanning_tree_edge_merger_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Grid maze edge merger: a start transaction (action 0) resets every cell label to its own
// index, an edge transaction (action 1) joins a cell with its right or lower neighbour and
// relabels the neighbour's set. One transaction is worked on at a time and gives one result.
// The label RAM (one read and one write port) holds MAX_WIDTH*MAX_HEIGHT entries and is
// walked one entry per cycle by a start and by a joining edge. After reset a clearing pass
// over every entry runs before the first transaction is taken; config writes are taken at
// any time. The next transaction is accepted while a result waits on the output.
module spanning_tree_edge_merger_unit #(
  parameter int MAX_WIDTH  = 32,
  parameter int MAX_HEIGHT = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [stem_pkg::REG_W-1:0] cfg_idx_i,
  input  wire logic [stem_pkg::CFG_W-1:0] cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       action_i,
  input  wire logic [stem_pkg::POS_W-1:0] cell_x_i,
  input  wire logic [stem_pkg::POS_W-1:0] cell_y_i,
  input  wire logic                       direction_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            wall_removed_o,
  output logic                            invalid_edge_o,
  output logic      [stem_pkg::POS_W-1:0] out_x_o,
  output logic      [stem_pkg::POS_W-1:0] out_y_o,
  output logic                            out_direction_o
);

  import stem_pkg::*;

  stem_cmd_t cmd;
  stem_sts_t sts;

  stem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  stem_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .action_i        (action_i),
    .cell_x_i        (cell_x_i),
    .cell_y_i        (cell_y_i),
    .direction_i     (direction_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .wall_removed_o  (wall_removed_o),
    .invalid_edge_o  (invalid_edge_o),
    .out_x_o         (out_x_o),
    .out_y_o         (out_y_o),
    .out_direction_o (out_direction_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/stem_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stem_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/stem_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stem_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire stem_pkg::stem_sts_t sts_i,
  output stem_pkg::stem_cmd_t     cmd_o,
  output logic                    in_ready_o
);

  import stem_pkg::*;

  stem_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.fill_we = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (sts_i.in_fire) begin
          cmd_o.load_in = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          if (sts_i.start) begin
            state_d = ST_FILL;
          end else if (sts_i.invalid) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_LOOK1;
          end
        end
      end
      ST_FILL: begin
        cmd_o.fill_we = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_DONE;
        end
      end
      ST_LOOK1: begin
        cmd_o.rd_i1 = 1'b1;
        state_d     = ST_LOOK2;
      end
      ST_LOOK2: begin
        cmd_o.rd_i2    = 1'b1;
        cmd_o.cap_keep = 1'b1;
        state_d        = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.cap_gone = 1'b1;
        if (sts_i.differ) begin
          cmd_o.set_removed = 1'b1;
          state_d           = ST_SCAN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_scan = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
    endcase
  end

  a_fire_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.in_fire |=> state_q != ST_IDLE)
    else $error("accepted transaction did not start work");

  a_load_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> sts_i.out_free)
    else $error("result loaded over a pending transaction");

endmodule

`default_nettype wire

@@ hw/rtl/stem_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stem_datapath #(
  parameter int MAX_WIDTH  = 32,
  parameter int MAX_HEIGHT = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire stem_pkg::stem_cmd_t         cmd_i,
  output stem_pkg::stem_sts_t              sts_o,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_ready_i,
  input  wire logic                        action_i,
  input  wire logic [stem_pkg::POS_W-1:0]  cell_x_i,
  input  wire logic [stem_pkg::POS_W-1:0]  cell_y_i,
  input  wire logic                        direction_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [stem_pkg::REG_W-1:0]  cfg_idx_i,
  input  wire logic [stem_pkg::CFG_W-1:0]  cfg_wdata_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             wall_removed_o,
  output logic                             invalid_edge_o,
  output logic      [stem_pkg::POS_W-1:0]  out_x_o,
  output logic      [stem_pkg::POS_W-1:0]  out_y_o,
  output logic                             out_direction_o
);

  import stem_pkg::*;

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int IDX_W = $clog2(CELLS);

  logic [CFG_W-1:0] grid_w_q, grid_h_q;
  logic [POS_W-1:0] x_q, y_q;
  logic             dir_q;
  logic             invalid_q, removed_q;
  logic [IDX_W-1:0] i1_q, i2_q, keep_q, gone_q, cnt_q, chk_addr_q;
  logic             chk_q;
  logic             out_valid_q;

  logic [DIM_W-1:0] w_eff, h_eff, x_ext, y_ext, nx, ny;
  logic             bad;
  logic [IDX_W-1:0] i1_d, i2_d;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  // grid in use saturates at the maximum
  assign w_eff = (DIM_W'(grid_w_q) > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : DIM_W'(grid_w_q);
  assign h_eff = (DIM_W'(grid_h_q) > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : DIM_W'(grid_h_q);

  assign x_ext = DIM_W'(cell_x_i);
  assign y_ext = DIM_W'(cell_y_i);
  assign nx    = (direction_i == DIR_DOWN) ? x_ext : x_ext + DIM_W'(1);
  assign ny    = (direction_i == DIR_DOWN) ? y_ext + DIM_W'(1) : y_ext;
  assign bad   = (x_ext >= w_eff) || (y_ext >= h_eff) || (nx >= w_eff) || (ny >= h_eff);

  assign i1_d = IDX_W'(y_ext) * IDX_W'(MAX_WIDTH) + IDX_W'(x_ext);
  assign i2_d = IDX_W'(ny) * IDX_W'(MAX_WIDTH) + IDX_W'(nx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= GRID_RESET;
      grid_h_q <= GRID_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_WIDTH:  grid_w_q <= cfg_wdata_i;
        REG_GRID_HEIGHT: grid_h_q <= cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + IDX_W'(1);
      end
      chk_q <= cmd_i.rd_scan;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_addr_q <= cnt_q;
    if (cmd_i.load_in) begin
      x_q       <= cell_x_i;
      y_q       <= cell_y_i;
      dir_q     <= direction_i;
      invalid_q <= (action_i == ACT_EDGE) && bad;
      removed_q <= 1'b0;
      i1_q      <= i1_d;
      i2_q      <= i2_d;
    end else if (cmd_i.set_removed) begin
      removed_q <= 1'b1;
    end
    if (cmd_i.cap_keep) begin
      keep_q <= ram_rdata;
    end
    if (cmd_i.cap_gone) begin
      gone_q <= ram_rdata;
    end
    if (cmd_i.load_out) begin
      wall_removed_o  <= removed_q;
      invalid_edge_o  <= invalid_q;
      out_x_o         <= x_q;
      out_y_o         <= y_q;
      out_direction_o <= dir_q;
    end
  end

  // relabel write comes in the cycle after the scan read of its entry
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = cnt_q;
    if (cmd_i.fill_we) begin
      ram_we = 1'b1;
    end else if (chk_q && (ram_rdata == gone_q)) begin
      ram_we    = 1'b1;
      ram_waddr = chk_addr_q;
      ram_wdata = keep_q;
    end
  end

  always_comb begin
    if (cmd_i.rd_i1) begin
      ram_raddr = i1_q;
    end else if (cmd_i.rd_i2) begin
      ram_raddr = i2_q;
    end else begin
      ram_raddr = cnt_q;
    end
  end

  stem_ram #(
    .WIDTH (IDX_W),
    .DEPTH (CELLS)
  ) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign sts_o.in_fire  = in_valid_i && in_ready_i;
  assign sts_o.start    = (action_i == ACT_START);
  assign sts_o.invalid  = bad;
  assign sts_o.cnt_last = (cnt_q == IDX_W'(CELLS - 1));
  assign sts_o.differ   = (ram_rdata != keep_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;

  a_fill_no_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill_we |-> !chk_q)
    else $error("fill overlaps a relabel write");

  a_removed_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.set_removed |-> !invalid_q)
    else $error("merge started on an invalid edge");

endmodule

`default_nettype wire
